// ===== rtl/lsc_pkg.sv =====
// shared constants for the lru slot cache ring
package lsc_pkg;

   localparam int SLOTS_DEFAULT      = 1024;
   localparam int OWNER_BITS_DEFAULT = 16;

   // fixed widths of the beat fields
   localparam int SLOT_W  = 10;
   localparam int OWNER_W = 16;

   localparam logic OP_ACCESS  = 1'b0;
   localparam logic OP_RELEASE = 1'b1;

endpackage

// ===== rtl/lsc_ram.sv =====
// generic single write port, single read port ram with bit write mask and registered read
module lsc_ram #(
   parameter int WIDTH = lsc_pkg::OWNER_BITS_DEFAULT,
   parameter int DEPTH = lsc_pkg::SLOTS_DEFAULT
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_mask,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < WIDTH; i++) begin
         if (wr_en && wr_mask[i]) begin
            mem_ff[wr_addr][i] <= wr_data[i];
         end
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/lru_slot_cache_ring.sv =====
// lru slot manager: doubly linked ring of slots in a link ram, owners in an owner ram
// a release, a miss or a hit on the victim or on the most recent slot passes through
//   ST_RDV, ST_RDS and ST_DONE; a hit that relinks its slot also steps through ST_WR
// one item at a time, with req_ready low until ST_DONE hands off the response; a relink
//   does two link ram reads and five masked writes through its single write port
// reset: synchronous; afterwards a clearing pass over all SLOTS entries rebuilds the ring and
//   clears ownership, with req_ready low until it ends
module lru_slot_cache_ring #(
   parameter int SLOTS      = lsc_pkg::SLOTS_DEFAULT,
   parameter int OWNER_BITS = lsc_pkg::OWNER_BITS_DEFAULT
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_opcode,
   input  logic [lsc_pkg::OWNER_W-1:0]  req_owner_id,
   input  logic                         req_owner_has_slot,
   input  logic [lsc_pkg::SLOT_W-1:0]   req_owner_slot,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lsc_pkg::SLOT_W-1:0]   rsp_slot,
   output logic                         rsp_hit,
   output logic                         rsp_fill_needed,
   output logic                         rsp_evicted_valid,
   output logic [lsc_pkg::OWNER_W-1:0]  rsp_evicted_owner
);

   localparam int SW     = $clog2(SLOTS);
   localparam int LW     = 2 * SW;
   localparam int OW     = OWNER_BITS + 1;
   localparam int SlotW  = lsc_pkg::SLOT_W;
   localparam int OwnW   = lsc_pkg::OWNER_W;
   localparam logic [SW-1:0] LastSlot = SW'(SLOTS - 1);
   localparam logic [LW-1:0] MaskAll  = {LW{1'b1}};
   localparam logic [LW-1:0] MaskNext = {{SW{1'b1}}, {SW{1'b0}}};
   localparam logic [LW-1:0] MaskPrev = {{SW{1'b0}}, {SW{1'b1}}};

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_RDV,
      ST_RDS,
      ST_WR,
      ST_DONE
   } state_type;

   typedef enum logic [2:0] {
      WS_SELF,
      WS_PREV_NEXT,
      WS_PV_NEXT,
      WS_NEXT_PREV,
      WS_VICT_PREV
   } wstep_type;

   state_type             state_ff;
   wstep_type             step_ff;
   logic [SW-1:0]         init_cnt_ff;
   logic [SW-1:0]         victim_ff;
   logic                  op_ff;
   logic                  has_ff;
   logic [OWNER_BITS-1:0] owner_ff;
   logic [SW-1:0]         s_ff;
   logic [SW-1:0]         vn_ff;
   logic [SW-1:0]         pv_ff;
   logic [SW-1:0]         n_ff;
   logic [SW-1:0]         p_ff;
   logic [SW-1:0]         res_slot_ff;
   logic                  res_hit_ff;
   logic                  res_fill_ff;
   logic                  res_ev_ff;
   logic [OWNER_BITS-1:0] res_evo_ff;
   logic                  rsp_valid_ff;
   logic [SlotW-1:0]      rsp_slot_ff;
   logic                  rsp_hit_ff;
   logic                  rsp_fill_ff;
   logic                  rsp_ev_ff;
   logic [OwnW-1:0]       rsp_evo_ff;

   logic                  link_we;
   logic [SW-1:0]         link_wa;
   logic [LW-1:0]         link_wm;
   logic [LW-1:0]         link_wd;
   logic [SW-1:0]         link_ra;
   logic [LW-1:0]         link_rd;
   logic [SW-1:0]         link_next;
   logic [SW-1:0]         link_prev;
   logic                  own_we;
   logic [SW-1:0]         own_wa;
   logic [OW-1:0]         own_wd;
   logic [OW-1:0]         own_rd;
   logic [SW-1:0]         init_next;
   logic [SW-1:0]         init_prev;
   logic                  req_slot_ok;
   logic [SW-1:0]         req_slot_idx;

   assign link_next    = link_rd[LW-1:SW];
   assign link_prev    = link_rd[SW-1:0];
   assign init_next    = (init_cnt_ff == LastSlot) ? '0 : init_cnt_ff + SW'(1);
   assign init_prev    = (init_cnt_ff == '0) ? LastSlot : init_cnt_ff - SW'(1);
   assign req_slot_ok  = 32'(req_owner_slot) < 32'(SLOTS);
   assign req_slot_idx = SW'(req_owner_slot);
   assign req_ready    = (state_ff == ST_IDLE);

   lsc_ram #(
      .WIDTH(LW),
      .DEPTH(SLOTS)
   ) u_link_ram (
      .clock  (clock),
      .wr_en  (link_we),
      .wr_addr(link_wa),
      .wr_mask(link_wm),
      .wr_data(link_wd),
      .rd_addr(link_ra),
      .rd_data(link_rd)
   );

   lsc_ram #(
      .WIDTH(OW),
      .DEPTH(SLOTS)
   ) u_owner_ram (
      .clock  (clock),
      .wr_en  (own_we),
      .wr_addr(own_wa),
      .wr_mask({OW{1'b1}}),
      .wr_data(own_wd),
      .rd_addr(victim_ff),
      .rd_data(own_rd)
   );

   // memory port control
   always_comb begin
      link_we = 1'b0;
      link_wa = s_ff;
      link_wm = MaskAll;
      link_wd = {victim_ff, pv_ff};
      link_ra = (state_ff == ST_RDV) ? s_ff : victim_ff;
      own_we  = 1'b0;
      own_wa  = victim_ff;
      own_wd  = {1'b1, owner_ff};
      case (state_ff)
         ST_INIT: begin
            link_we = 1'b1;
            link_wa = init_cnt_ff;
            link_wd = {init_next, init_prev};
            own_we  = 1'b1;
            own_wa  = init_cnt_ff;
            own_wd  = '0;
         end
         ST_RDS: begin
            if (op_ff == lsc_pkg::OP_RELEASE) begin
               own_we = has_ff;
               own_wa = s_ff;
               own_wd = '0;
            end else begin
               own_we = !has_ff;
            end
         end
         ST_WR: begin
            link_we = 1'b1;
            case (step_ff)
               WS_SELF: begin
                  link_wa = s_ff;
                  link_wm = MaskAll;
                  link_wd = {victim_ff, pv_ff};
               end
               WS_PREV_NEXT: begin
                  link_wa = p_ff;
                  link_wm = MaskNext;
                  link_wd = {n_ff, n_ff};
               end
               WS_PV_NEXT: begin
                  link_wa = pv_ff;
                  link_wm = MaskNext;
                  link_wd = {s_ff, s_ff};
               end
               WS_NEXT_PREV: begin
                  link_wa = n_ff;
                  link_wm = MaskPrev;
                  link_wd = {p_ff, p_ff};
               end
               WS_VICT_PREV: begin
                  link_wa = victim_ff;
                  link_wm = MaskPrev;
                  link_wd = {s_ff, s_ff};
               end
               default: begin
                  link_we = 1'b0;
               end
            endcase
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         step_ff      <= WS_SELF;
         init_cnt_ff  <= '0;
         victim_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_DONE && (!rsp_valid_ff || rsp_ready)) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_INIT: begin
               init_cnt_ff <= init_next;
               if (init_cnt_ff == LastSlot) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (req_valid) begin
                  op_ff    <= req_opcode;
                  has_ff   <= req_owner_has_slot && req_slot_ok;
                  owner_ff <= OWNER_BITS'(32'(req_owner_id));
                  s_ff     <= req_slot_idx;
                  state_ff <= ST_RDV;
               end
            end
            ST_RDV: begin
               vn_ff    <= link_next;
               pv_ff    <= link_prev;
               state_ff <= ST_RDS;
            end
            ST_RDS: begin
               n_ff        <= link_next;
               p_ff        <= link_prev;
               res_slot_ff <= s_ff;
               res_hit_ff  <= 1'b0;
               res_fill_ff <= 1'b0;
               res_ev_ff   <= 1'b0;
               res_evo_ff  <= '0;
               state_ff    <= ST_DONE;
               if (op_ff == lsc_pkg::OP_RELEASE) begin
                  if (!has_ff) begin
                     res_slot_ff <= '0;
                  end
               end else if (has_ff) begin
                  res_hit_ff <= 1'b1;
                  if (s_ff == victim_ff) begin
                     victim_ff <= vn_ff;
                  end else if (s_ff != pv_ff) begin
                     step_ff  <= WS_SELF;
                     state_ff <= ST_WR;
                  end
               end else begin
                  res_slot_ff <= victim_ff;
                  res_fill_ff <= 1'b1;
                  res_ev_ff   <= own_rd[OWNER_BITS];
                  res_evo_ff  <= own_rd[OWNER_BITS] ? own_rd[OWNER_BITS-1:0] : '0;
                  victim_ff   <= vn_ff;
               end
            end
            ST_WR: begin
               case (step_ff)
                  WS_SELF:      step_ff <= WS_PREV_NEXT;
                  WS_PREV_NEXT: step_ff <= WS_PV_NEXT;
                  WS_PV_NEXT:   step_ff <= WS_NEXT_PREV;
                  WS_NEXT_PREV: step_ff <= WS_VICT_PREV;
                  default:      state_ff <= ST_DONE;
               endcase
            end
            ST_DONE: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_slot_ff  <= SlotW'(res_slot_ff);
                  rsp_hit_ff   <= res_hit_ff;
                  rsp_fill_ff  <= res_fill_ff;
                  rsp_ev_ff    <= res_ev_ff;
                  rsp_evo_ff   <= OwnW'(res_evo_ff);
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_slot          = rsp_slot_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_fill_needed   = rsp_fill_ff;
   assign rsp_evicted_valid = rsp_ev_ff;
   assign rsp_evicted_owner = rsp_evo_ff;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("accepted beat did not make the block busy");

   a_evict_needs_fill: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((!rsp_evicted_valid || rsp_fill_needed) && !(rsp_hit && rsp_fill_needed)))
      else $error("inconsistent hit, fill and eviction flags");

   a_victim_moves_on_decide: assert property (@(posedge clock) disable iff (reset)
      (!$stable(victim_ff) && !$past(reset)) |-> $past(state_ff == ST_RDS))
      else $error("victim moved outside the decision cycle");

   a_relink_distinct: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WR) |-> (s_ff != victim_ff && s_ff != pv_ff && n_ff != victim_ff))
      else $error("relink started on victim or most recent slot");

endmodule
